@@ src/frame_reassembly_slot_tracker_macros.svh @@
// assertion macros for the frame reassembly slot tracker checker
`ifndef FRAME_REASSEMBLY_SLOT_TRACKER_MACROS_SVH
`define FRAME_REASSEMBLY_SLOT_TRACKER_MACROS_SVH

// same-cycle implication, reset masked
`define FRST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frst check failed");

// next-cycle implication, reset masked
`define FRST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frst check failed");

`endif

@@ src/frst_pkg.sv @@
// shared types and constants of the frame reassembly slot tracker
package frst_pkg;

  localparam logic [31:0] SMALL_INDEX_CAP  = 32'h0000ffff;
  localparam logic [31:0] LARGE_INDEX_MARK = 32'hffff0000;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;

  localparam logic [2:0] REG_PKT_TYPE  = 3'd0;
  localparam logic [2:0] REG_MAX_VER   = 3'd1;
  localparam logic [2:0] REG_MAX_FRAME = 3'd2;
  localparam logic [2:0] REG_MAX_PKT   = 3'd3;
  localparam logic [2:0] REG_UNK_POS   = 3'd4;

  localparam logic [15:0] RST_PKT_TYPE  = 16'd0;
  localparam logic [15:0] RST_MAX_VER   = 16'd1;
  localparam logic [15:0] RST_MAX_FRAME = 16'd2048;
  localparam logic [15:0] RST_MAX_PKT   = 16'd64;
  localparam logic [15:0] RST_UNK_POS   = 16'hffff;

  typedef struct packed {
    logic [15:0] pkt_type;
    logic [15:0] max_ver;
    logic [15:0] max_frame;
    logic [15:0] max_pkt;
    logic [15:0] unk_pos;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic check;
    logic scan_clr;
    logic fstep;
    logic resolve;
    logic dstep;
    logic demit;
    logic init;
    logic acc;
    logic final_ok;
  } cmd_t;

  typedef struct packed {
    logic hdr_ok;
    logic pos_ok;
    logic scan_last;
    logic has_match;
    logic has_free;
    logic has_old;
    logic d_found;
    logic acc_reach;
  } sts_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_FSCAN, S_RESOLVE, S_DSCAN, S_DEMIT, S_INIT, S_ACC, S_FINAL
  } state_t;

endpackage

@@ src/frst_regs.sv @@
// configuration register file behind the apb port
module frst_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output frst_pkg::cfg_t cfg
);
  import frst_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pkt_type  <= RST_PKT_TYPE;
      cfg.max_ver   <= RST_MAX_VER;
      cfg.max_frame <= RST_MAX_FRAME;
      cfg.max_pkt   <= RST_MAX_PKT;
      cfg.unk_pos   <= RST_UNK_POS;
    end else if (wr) begin
      unique case (idx)
        REG_PKT_TYPE:  cfg.pkt_type  <= pwdata[15:0];
        REG_MAX_VER:   cfg.max_ver   <= pwdata[15:0];
        REG_MAX_FRAME: cfg.max_frame <= pwdata[15:0];
        REG_MAX_PKT:   cfg.max_pkt   <= pwdata[15:0];
        REG_UNK_POS:   cfg.unk_pos   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PKT_TYPE:  prdata = {16'd0, cfg.pkt_type};
      REG_MAX_VER:   prdata = {16'd0, cfg.max_ver};
      REG_MAX_FRAME: prdata = {16'd0, cfg.max_frame};
      REG_MAX_PKT:   prdata = {16'd0, cfg.max_pkt};
      REG_UNK_POS:   prdata = {16'd0, cfg.unk_pos};
      default:       prdata = 32'd0;
    endcase
  end
endmodule

@@ src/frst_dp.sv @@
// slot table, header check, scan trackers and result register
module frst_dp #(
  parameter int SLOTS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  frst_pkg::cfg_t cfg,
  input  frst_pkg::cmd_t cmd,
  output frst_pkg::sts_t sts,
  input  logic [15:0]    packet_kind,
  input  logic [15:0]    header_version,
  input  logic [15:0]    position_id,
  input  logic [31:0]    frame_number,
  input  logic [15:0]    frame_total,
  input  logic [15:0]    packet_entities,
  input  logic [15:0]    range_code,
  input  logic [63:0]    time_stamp,
  output logic           result_valid,
  output logic           is_status,
  output logic [1:0]     status,
  output logic [3:0]     slot,
  output logic [31:0]    out_frame_number,
  output logic [15:0]    received_count,
  output logic [15:0]    expected_count,
  output logic           complete,
  output logic [15:0]    out_range_code,
  output logic [63:0]    out_time_stamp,
  output logic [15:0]    write_offset,
  output logic           last
);
  import frst_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // slot table
  logic [31:0] slot_fn  [SLOTS];
  logic [15:0] slot_exp [SLOTS];
  logic [15:0] slot_rcv [SLOTS];
  logic [15:0] slot_rng [SLOTS];
  logic [63:0] slot_tim [SLOTS];
  logic [31:0] latest;
  logic [15:0] locked;

  // latched header
  logic [15:0] h_kind, h_ver, h_pos, h_total, h_pkt, h_rng;
  logic [31:0] h_fn;
  logic [63:0] h_tim;

  // scan trackers
  logic [IW-1:0] idx, sel, f_match, f_free, f_old, d_pick;
  logic          f_match_ok, f_free_ok, f_old_ok, d_ok;
  logic [31:0]   omin, dmin, fs;
  logic [15:0]   offset;

  // combinational
  logic [IW-1:0] rd_addr, sel_next;
  logic [31:0]   r_fn;
  logic [15:0]   r_exp, r_rcv, r_rng;
  logic [63:0]   r_tim;
  logic          hdr_ok, wrap, pos_ok, i_match, i_free, i_old, i_d;
  logic [15:0]   locked_eff;
  logic [16:0]   sum;
  logic          over, reach;

  logic        e_valid, e_is, e_cmpl, e_last;
  logic [1:0]  e_st;
  logic [3:0]  e_slot;
  logic [31:0] e_fn;
  logic [15:0] e_rcv, e_exp, e_rng, e_off;
  logic [63:0] e_tim;

  always_comb begin
    if (cmd.fstep || cmd.dstep) rd_addr = idx;
    else if (cmd.demit && d_ok) rd_addr = d_pick;
    else                        rd_addr = sel;
  end

  assign r_fn  = slot_fn[rd_addr];
  assign r_exp = slot_exp[rd_addr];
  assign r_rcv = slot_rcv[rd_addr];
  assign r_rng = slot_rng[rd_addr];
  assign r_tim = slot_tim[rd_addr];

  assign hdr_ok = (h_kind == cfg.pkt_type) && (h_ver <= cfg.max_ver) &&
                  (h_pkt <= cfg.max_pkt) && (h_pos != cfg.unk_pos) &&
                  (h_total <= cfg.max_frame) && (h_pkt <= h_total);
  assign wrap       = (h_fn < SMALL_INDEX_CAP) && (latest > LARGE_INDEX_MARK);
  assign locked_eff = wrap ? cfg.unk_pos : locked;
  assign pos_ok     = (locked_eff == cfg.unk_pos) || (locked_eff == h_pos);

  assign i_match = (r_fn == h_fn) && (r_exp != 16'd0);
  assign i_free  = (r_exp == 16'd0);
  assign i_old   = (r_fn < h_fn) && (!f_old_ok || r_fn < omin);
  assign i_d     = (r_exp != 16'd0) && (idx != sel) && (r_fn < fs) &&
                   (!d_ok || r_fn < dmin);

  assign sum   = {1'b0, r_rcv} + {1'b0, h_pkt};
  assign over  = sum > {1'b0, r_exp};
  assign reach = (h_total != 16'd0) && !over && (sum[15:0] == r_exp);

  always_comb begin
    if (f_match_ok)    sel_next = f_match;
    else if (f_free_ok) sel_next = f_free;
    else                sel_next = f_old;
  end

  always_comb begin
    sts.hdr_ok    = hdr_ok;
    sts.pos_ok    = pos_ok;
    sts.scan_last = (idx == IW'(SLOTS - 1));
    sts.has_match = f_match_ok;
    sts.has_free  = f_free_ok;
    sts.has_old   = f_old_ok;
    sts.d_found   = d_ok;
    sts.acc_reach = reach;
  end

  // result of this cycle
  always_comb begin
    e_valid = 1'b0;
    e_is    = 1'b1;
    e_st    = ST_OK;
    e_slot  = 4'd0;
    e_fn    = 32'd0;
    e_rcv   = 16'd0;
    e_exp   = 16'd0;
    e_cmpl  = 1'b0;
    e_rng   = 16'd0;
    e_tim   = 64'd0;
    e_off   = 16'd0;
    e_last  = 1'b1;
    if (cmd.check) begin
      if (!hdr_ok) begin
        e_valid = 1'b1;
        e_st    = ST_ERR;
      end else if (!pos_ok) begin
        e_valid = 1'b1;
        e_st    = ST_SKIP;
      end
    end else if (cmd.resolve) begin
      if (!f_match_ok && !f_free_ok && !f_old_ok) begin
        e_valid = 1'b1;
        e_st    = ST_SKIP;
      end
    end else if (cmd.demit) begin
      e_valid = 1'b1;
      e_is    = 1'b0;
      e_slot  = 4'(rd_addr);
      e_fn    = r_fn;
      e_rcv   = r_rcv;
      e_exp   = r_exp;
      e_cmpl  = (r_rcv == r_exp);
      e_rng   = r_rng;
      e_tim   = r_tim;
      e_last  = 1'b0;
    end else if (cmd.acc) begin
      e_slot = 4'(sel);
      e_fn   = h_fn;
      if (h_total == 16'd0) begin
        e_valid = 1'b1;
        e_st    = ST_SKIP;
      end else if (over) begin
        e_valid = 1'b1;
        e_st    = ST_ERR;
      end else if (!reach) begin
        e_valid = 1'b1;
        e_off   = r_rcv;
      end
    end else if (cmd.final_ok) begin
      e_valid = 1'b1;
      e_slot  = 4'(sel);
      e_fn    = h_fn;
      e_off   = offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= e_valid;
    end
    is_status        <= e_is;
    status           <= e_st;
    slot             <= e_slot;
    out_frame_number <= e_fn;
    received_count   <= e_rcv;
    expected_count   <= e_exp;
    complete         <= e_cmpl;
    out_range_code   <= e_rng;
    out_time_stamp   <= e_tim;
    write_offset     <= e_off;
    last             <= e_last;
  end

  // header latch and scan trackers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      h_kind  <= packet_kind;
      h_ver   <= header_version;
      h_pos   <= position_id;
      h_fn    <= frame_number;
      h_total <= frame_total;
      h_pkt   <= packet_entities;
      h_rng   <= range_code;
      h_tim   <= time_stamp;
    end
    if (cmd.resolve) begin
      sel <= sel_next;
      fs  <= omin;
    end
    if (cmd.acc) begin
      fs     <= h_fn;
      offset <= r_rcv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      f_match_ok <= 1'b0;
      f_free_ok  <= 1'b0;
      f_old_ok   <= 1'b0;
      d_ok       <= 1'b0;
    end else if (cmd.scan_clr) begin
      idx        <= '0;
      f_match_ok <= 1'b0;
      f_free_ok  <= 1'b0;
      f_old_ok   <= 1'b0;
      d_ok       <= 1'b0;
    end else if (cmd.fstep) begin
      idx <= idx + 1'b1;
      if (i_match && !f_match_ok) begin
        f_match_ok <= 1'b1;
        f_match    <= idx;
      end
      if (i_free) begin
        f_free_ok <= 1'b1;
        f_free    <= idx;
      end
      if (i_old) begin
        f_old_ok <= 1'b1;
        f_old    <= idx;
        omin     <= r_fn;
      end
    end else if (cmd.dstep) begin
      idx <= idx + 1'b1;
      if (i_d) begin
        d_ok   <= 1'b1;
        d_pick <= idx;
        dmin   <= r_fn;
      end
    end
  end

  // slot table and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      latest <= 32'd0;
      locked <= RST_UNK_POS;
      for (int i = 0; i < SLOTS; i++) begin
        slot_fn[i]  <= 32'd0;
        slot_exp[i] <= 16'd0;
        slot_rcv[i] <= 16'd0;
        slot_rng[i] <= 16'd0;
        slot_tim[i] <= 64'd0;
      end
    end else begin
      if (cmd.check && hdr_ok) begin
        if (wrap) begin
          for (int i = 0; i < SLOTS; i++) begin
            slot_fn[i]  <= 32'd0;
            slot_exp[i] <= 16'd0;
            slot_rcv[i] <= 16'd0;
            slot_rng[i] <= 16'd0;
            slot_tim[i] <= 64'd0;
          end
        end
        if (locked_eff == cfg.unk_pos) locked <= h_pos;
        else                           locked <= locked_eff;
        if (pos_ok) begin
          if ((wrap ? 32'd0 : latest) < h_fn) latest <= h_fn;
          else if (wrap)                      latest <= 32'd0;
        end else if (wrap) begin
          latest <= 32'd0;
        end
      end
      if (cmd.demit) begin
        slot_fn[rd_addr]  <= 32'd0;
        slot_exp[rd_addr] <= 16'd0;
        slot_rcv[rd_addr] <= 16'd0;
        slot_rng[rd_addr] <= 16'd0;
        slot_tim[rd_addr] <= 64'd0;
      end
      if (cmd.init) begin
        slot_fn[sel]  <= h_fn;
        slot_exp[sel] <= h_total;
        slot_rcv[sel] <= 16'd0;
        slot_rng[sel] <= h_rng;
        slot_tim[sel] <= h_tim;
      end
      if (cmd.acc && h_total != 16'd0 && !over) begin
        slot_rcv[sel] <= sum[15:0];
      end
    end
  end
endmodule

@@ src/frst_ctrl.sv @@
// sequencer for header check, slot scans and deliveries
module frst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  frst_pkg::sts_t sts,
  output frst_pkg::cmd_t cmd
);
  import frst_pkg::*;

  state_t state, state_next;
  logic   ret_init;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret_init <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RESOLVE) ret_init <= 1'b1;
      else if (state == S_ACC) ret_init <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_CHECK;
      S_CHECK:   state_next = (sts.hdr_ok && sts.pos_ok) ? S_FSCAN : S_IDLE;
      S_FSCAN:   if (sts.scan_last) state_next = S_RESOLVE;
      S_RESOLVE: begin
        priority if (sts.has_match) state_next = S_ACC;
        else if (sts.has_free)      state_next = S_INIT;
        else if (sts.has_old)       state_next = S_DSCAN;
        else                        state_next = S_IDLE;
      end
      S_DSCAN:   if (sts.scan_last) state_next = S_DEMIT;
      S_DEMIT: begin
        if (sts.d_found)   state_next = S_DSCAN;
        else if (ret_init) state_next = S_INIT;
        else               state_next = S_FINAL;
      end
      S_INIT:    state_next = S_ACC;
      S_ACC:     state_next = sts.acc_reach ? S_DSCAN : S_IDLE;
      S_FINAL:   state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:    cmd.latch = start;
      S_CHECK: begin
        cmd.check    = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_FSCAN:   cmd.fstep = 1'b1;
      S_RESOLVE: begin
        cmd.resolve  = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_DSCAN:   cmd.dstep = 1'b1;
      S_DEMIT: begin
        cmd.demit    = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_INIT:    cmd.init = 1'b1;
      S_ACC: begin
        cmd.acc      = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_FINAL:   cmd.final_ok = 1'b1;
      default: ;
    endcase
  end
endmodule

@@ src/frame_reassembly_slot_tracker.sv @@
// top level of the frame reassembly slot tracker
// one packet header per transaction: start is taken when busy is low, and
// busy drops in the cycle that carries the last result of that header.
// results come on result_valid for one cycle each and cannot be held off:
// zero or more frame deliveries (is_status 0), then one status result with
// last high. a header that fails the check gives its status through the
// check state and the result register. otherwise the check and the slot
// search come first, each delivered frame adds a search pass through the
// slot table and a delivery state, then setting up the slot, counting
// entities and closing follow as needed, and the result register comes
// last. the slot table is read one entry per cycle by a single search
// unit.
module frame_reassembly_slot_tracker #(
  parameter int SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // header transaction
  input  logic        start,
  output logic        busy,
  input  logic [15:0] packet_kind,
  input  logic [15:0] header_version,
  input  logic [15:0] position_id,
  input  logic [31:0] frame_number,
  input  logic [15:0] frame_total,
  input  logic [15:0] packet_entities,
  input  logic [15:0] range_code,
  input  logic [63:0] time_stamp,
  // result transactions
  output logic        result_valid,
  output logic        is_status,
  output logic [1:0]  status,
  output logic [3:0]  slot,
  output logic [31:0] out_frame_number,
  output logic [15:0] received_count,
  output logic [15:0] expected_count,
  output logic        complete,
  output logic [15:0] out_range_code,
  output logic [63:0] out_time_stamp,
  output logic [15:0] write_offset,
  output logic        last
);
  import frst_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // register file; the user must hold it stable while a header is in work, the block does not enforce it
  frst_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  // sequencer
  frst_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .sts, .cmd
  );

  // slot table and result register
  frst_dp #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst, .cfg, .cmd, .sts,
    .packet_kind, .header_version, .position_id, .frame_number,
    .frame_total, .packet_entities, .range_code, .time_stamp,
    .result_valid, .is_status, .status, .slot, .out_frame_number,
    .received_count, .expected_count, .complete, .out_range_code,
    .out_time_stamp, .write_offset, .last
  );
endmodule

@@ src/frst_checker.sv @@
// port-level checker of the frame reassembly slot tracker, with its bind
`include "frame_reassembly_slot_tracker_macros.svh"

module frst_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input logic is_status,
  input logic last
);
  // a delivery never closes a header
  `FRST_ASSERT_NOW(a_deliv_not_last, result_valid && !is_status, !last)
  // the status result always closes a header
  `FRST_ASSERT_NOW(a_status_last, result_valid && is_status, last)
  // the closing result frees the block in the same cycle
  `FRST_ASSERT_NOW(a_last_idle, result_valid && last, !busy)
  // a taken header keeps the block busy the next cycle
  `FRST_ASSERT_NEXT(a_start_busy, start && !busy, busy)
endmodule

bind frame_reassembly_slot_tracker frst_checker u_frst_checker (.*);
